/* rtl/ufd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants of the ultrasonic frame decoder
// Byte codes, field widths and the result record passed between stages.
// ----------------------------------------------------------------------------
package ufd_pkg;

   // field widths
   localparam int ByteWidth = 8;
   localparam int DistWidth = 14;
   localparam int MinWidth  = 16;
   localparam int RawWidth  = 16;

   // frame byte codes
   localparam logic [ByteWidth-1:0] FrameHeader = 8'hFF;
   localparam logic [ByteWidth-1:0] ZeroByte    = 8'h00;

   // reset value of the minimum distance register
   localparam logic [MinWidth-1:0] MinDistanceReset = 16'd30;

   // raw / 10 as (raw * 0xCCCD) >> 19, exact for every 16-bit raw value
   localparam int                  RecipWidth = 17;
   localparam logic [RecipWidth-1:0] RecipTen = 17'd52429;
   localparam int                  RecipShift = 19;
   localparam int                  ProdWidth  = RawWidth + RecipWidth;

   // distance codes
   localparam logic signed [DistWidth-1:0] DistBlocked = -14'sd1;
   localparam logic signed [DistWidth-1:0] DistZero    = 14'sd0;

   // frame position after the header
   typedef enum logic [1:0] {
      POS_START = 2'd0,
      POS_HIGH  = 2'd1,
      POS_LOW   = 2'd2,
      POS_SUM   = 2'd3
   } pos_type;

   // one result item
   typedef struct packed {
      logic signed [DistWidth-1:0] distance_cm;
      logic                        checksum_error;
   } result_type;

endpackage
`default_nettype wire

/* rtl/ufd_frame_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_frame_core: frame state and byte decode
// Holds the frame bytes and the held distance; decodes one byte per step
// and presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module ufd_frame_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                step_en,
   input  wire [ufd_pkg::ByteWidth-1:0]       rx_byte,
   input  wire [ufd_pkg::MinWidth-1:0]        min_distance_mm,
   output ufd_pkg::result_type                result
);

   ufd_pkg::pos_type                         pos_ff, pos_in;
   logic [ufd_pkg::ByteWidth-1:0]            header_ff, header_in;
   logic [ufd_pkg::ByteWidth-1:0]            high_ff, high_in;
   logic [ufd_pkg::ByteWidth-1:0]            low_ff, low_in;
   logic signed [ufd_pkg::DistWidth-1:0]     held_ff, held_in;
   logic                                     err;
   logic [ufd_pkg::ByteWidth-1:0]            sum;
   logic [ufd_pkg::RawWidth-1:0]             raw;
   logic [ufd_pkg::ProdWidth-1:0]            prod;
   logic [ufd_pkg::DistWidth-1:0]            quot;

   // checksum and scaled distance of the stored frame
   assign sum  = header_ff + high_ff + low_ff;
   assign raw  = {high_ff, low_ff};
   assign prod = ufd_pkg::ProdWidth'(raw) * ufd_pkg::ProdWidth'(ufd_pkg::RecipTen);
   assign quot = prod[ufd_pkg::RecipShift +: ufd_pkg::DistWidth];

   // next state for the byte at hand
   always_comb begin
      pos_in    = pos_ff;
      header_in = header_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      held_in   = held_ff;
      err       = 1'b0;
      if (rx_byte == ufd_pkg::FrameHeader) begin
         header_in = ufd_pkg::FrameHeader;
         pos_in    = ufd_pkg::POS_START;
      end else begin
         case (pos_ff)
            ufd_pkg::POS_START: begin
               high_in = rx_byte;
               pos_in  = ufd_pkg::POS_HIGH;
            end
            ufd_pkg::POS_HIGH: begin
               low_in = rx_byte;
               if (rx_byte == ufd_pkg::ZeroByte) begin
                  // blocked or out of range: restart the frame
                  held_in = ufd_pkg::DistBlocked;
                  pos_in  = ufd_pkg::POS_START;
               end else begin
                  pos_in = ufd_pkg::POS_LOW;
               end
            end
            ufd_pkg::POS_LOW: begin
               if (rx_byte == sum) begin
                  if (raw > min_distance_mm) begin
                     held_in = $signed(quot);
                  end else begin
                     held_in = ufd_pkg::DistZero;
                  end
               end else begin
                  err = 1'b1;
               end
               pos_in    = ufd_pkg::POS_START;
               header_in = ufd_pkg::ZeroByte;
               high_in   = ufd_pkg::ZeroByte;
               low_in    = ufd_pkg::ZeroByte;
            end
            default: begin
               pos_in = ufd_pkg::POS_START;
            end
         endcase
      end
   end

   assign result.distance_cm    = held_in;
   assign result.checksum_error = err;

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= ufd_pkg::POS_START;
         header_ff <= ufd_pkg::ZeroByte;
         high_ff   <= ufd_pkg::ZeroByte;
         low_ff    <= ufd_pkg::ZeroByte;
         held_ff   <= ufd_pkg::DistZero;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         header_ff <= header_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         held_ff   <= held_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/ufd_result_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_result_reg: result register of the decoder
// Holds one result until the receiver takes it; reports when it can load.
// ----------------------------------------------------------------------------
module ufd_result_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  wire ufd_pkg::result_type result_in,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ufd_pkg::result_type  result_out
);

   logic                 valid_ff, valid_in;
   ufd_pkg::result_type  data_ff;

   // free when empty or being emptied this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = data_ff;

endmodule
`default_nettype wire

/* rtl/ultrasonic_frame_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_frame_decoder: serial frame decoder of an ultrasonic sensor
// Each received byte on the req_ channel gives one result on the rsp_
// channel: the held distance in cm and a checksum error flag.
//
// Channels: req_valid/req_ready carry req_rx_byte; rsp_valid/rsp_ready carry
// rsp_distance_cm and rsp_checksum_error. csr_we/csr_wdata write the
// minimum distance in mm (reset 30); write it only while no transaction is
// in flight.
// Path: an accepted byte passes the input register, then the frame decode
// and the result register. Throughput: one byte per cycle unless rsp_ready
// stalls, set by the combinational frame decode between the two registers.
// Reset: synchronous; clears both registers' valid bits and the frame state,
// held distance becomes 0.
// Stall: a result waiting on rsp_ready keeps the input register full; new
// bytes are refused once both are full, and nothing is dropped.
// ----------------------------------------------------------------------------
module ultrasonic_frame_decoder (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [ufd_pkg::ByteWidth-1:0]        req_rx_byte,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [ufd_pkg::DistWidth-1:0] rsp_distance_cm,
   output logic                                 rsp_checksum_error,
   input  wire                                  csr_we,
   input  wire  [ufd_pkg::MinWidth-1:0]         csr_wdata
);

   logic                           in_valid_ff, in_valid_in;
   logic [ufd_pkg::ByteWidth-1:0]  in_byte_ff;
   logic [ufd_pkg::MinWidth-1:0]   min_dist_ff;
   logic                           out_free;
   logic                           step_fire;
   logic                           req_fire;
   ufd_pkg::result_type            step_result;
   ufd_pkg::result_type            rsp_result;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= ufd_pkg::MinDistanceReset;
      end else if (csr_we) begin
         min_dist_ff <= csr_wdata;
      end
   end

   // input register handshake
   assign step_fire   = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || step_fire;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame decode
   ufd_frame_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step_en         (step_fire),
      .rx_byte         (in_byte_ff),
      .min_distance_mm (min_dist_ff),
      .result          (step_result)
   );

   // result register
   ufd_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (step_fire),
      .result_in  (step_result),
      .can_load   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .result_out (rsp_result)
   );

   assign rsp_distance_cm    = rsp_result.distance_cm;
   assign rsp_checksum_error = rsp_result.checksum_error;

`ifndef SYNTHESIS
   // a decoded byte always shows up as a result in the next cycle
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid)
      else $error("decoded byte produced no result");

   // a byte held back by a stalled result stays in the input register
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost during stall");

   // an accepted byte always lands in the input register
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff && (in_byte_ff == $past(req_rx_byte)))
      else $error("accepted byte not captured");

   // nothing is in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_valid_ff)
      else $error("valid state survived reset");
`endif

endmodule
`default_nettype wire
